FILE: rtl/rfc_pkg.sv
// Shared types and constants of the floor texel coordinate unit.
`timescale 1ns / 1ps
package rfc_pkg;

	localparam int SCREEN_HEIGHT_DEF = 480;
	localparam int TEX_SIZE_DEF      = 512;

	localparam int CELL_W = 8;
	localparam int FRAC_W = 16;
	localparam int POS_W  = 24;
	localparam int WALL_W = 25;
	localparam int ROW_W  = 10;
	localparam int DIST_W = ROW_W + 1;
	localparam int TEX_W  = 9;

	localparam int QUEUE_DEPTH = 4;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic CMD_SETUP = 1'b0;
	localparam logic CMD_ROW   = 1'b1;

	localparam logic REG_PLAYER_X = 1'b0;
	localparam logic REG_PLAYER_Y = 1'b1;

	localparam logic [POS_W-1:0] ONE_Q16 = POS_W'(1 << FRAC_W);

	// One row request with the column state it was issued against
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [DIST_W-1:0] span;
		logic              one;
		logic              ceil;
		logic [WALL_W-1:0] wfx;
		logic [WALL_W-1:0] wfy;
		logic [POS_W-1:0]  cwd;
	} entry_t;

endpackage

FILE: rtl/raycast_floor_texel_coords_unit.sv
// Top level of the floor and ceiling texel coordinate unit.
// A setup beat (cmd 0) latches the floor point at the foot of the wall, the
// wall distance and the boundary row when accepted and gives no result; each
// row beat (cmd 1) gives one result in order. One beat is taken per clock
// while the queue is not full. A row beat reaches the result ports through
// the queue and the back pipeline: one stage per quotient bit of the row
// distance divider and of the 16-bit weight divider, with a clamp test
// between them, then multiply, add and texel scaling. The back pipeline
// halts as a whole while a result waits unpopped; the front keeps taking
// beats until its four-entry queue fills.
`timescale 1ns / 1ps
module raycast_floor_texel_coords_unit import rfc_pkg::*; #(
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int TEX_SIZE      = TEX_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              push,
	output logic              full,
	input  logic              cmd,
	input  logic [CELL_W-1:0] cell_x,
	input  logic [CELL_W-1:0] cell_y,
	input  logic              hit_side,
	input  logic              dir_x_positive,
	input  logic              dir_y_positive,
	input  logic [FRAC_W-1:0] wall_fraction,
	input  logic [POS_W-1:0]  wall_distance,
	input  logic [ROW_W-1:0]  boundary_row,
	input  logic [ROW_W-1:0]  row,
	output logic              empty,
	input  logic              pop,
	output logic [ROW_W-1:0]  out_row,
	output logic [TEX_W-1:0]  texel_u,
	output logic [TEX_W-1:0]  texel_v,
	output logic              is_ceiling
);

	logic [POS_W-1:0] player_x_q, player_y_q;
	logic             accept, enq, deq, q_empty;
	entry_t           enq_entry, head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PLAYER_Y) ? DATA_W'(player_y_q) : DATA_W'(player_x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= '0;
			player_y_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_PLAYER_X) begin
				player_x_q <= pwdata[POS_W-1:0];
			end else begin
				player_y_q <= pwdata[POS_W-1:0];
			end
		end
	end

	assign accept = push && !full;

	rfc_front #(
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cmd            (cmd),
		.cell_x         (cell_x),
		.cell_y         (cell_y),
		.hit_side       (hit_side),
		.dir_x_positive (dir_x_positive),
		.dir_y_positive (dir_y_positive),
		.wall_fraction  (wall_fraction),
		.wall_distance  (wall_distance),
		.boundary_row   (boundary_row),
		.row            (row),
		.enq            (enq),
		.enq_entry      (enq_entry)
	);

	rfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (enq),
		.enq_entry (enq_entry),
		.full      (full),
		.deq       (deq),
		.q_empty   (q_empty),
		.head      (head)
	);

	rfc_back #(
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.TEX_SIZE     (TEX_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.deq        (deq),
		.player_x   (player_x_q),
		.player_y   (player_y_q),
		.pop        (pop),
		.empty      (empty),
		.out_row    (out_row),
		.texel_u    (texel_u),
		.texel_v    (texel_v),
		.is_ceiling (is_ceiling)
	);

endmodule

FILE: rtl/rfc_front.sv
// Front end: column setup latch and classification of row requests.
`timescale 1ns / 1ps
module rfc_front import rfc_pkg::*; #(
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              cmd,
	input  logic [CELL_W-1:0] cell_x,
	input  logic [CELL_W-1:0] cell_y,
	input  logic              hit_side,
	input  logic              dir_x_positive,
	input  logic              dir_y_positive,
	input  logic [FRAC_W-1:0] wall_fraction,
	input  logic [POS_W-1:0]  wall_distance,
	input  logic [ROW_W-1:0]  boundary_row,
	input  logic [ROW_W-1:0]  row,
	output logic              enq,
	output entry_t            enq_entry
);

	logic [WALL_W-1:0] wfx_q, wfy_q;
	logic [POS_W-1:0]  cwd_q;
	logic [ROW_W-1:0]  bound_q;

	logic [WALL_W-1:0] cx, cy, nx, ny;
	logic [DIST_W-1:0] twice, hgt, span;

	assign cx = WALL_W'(cell_x) << FRAC_W;
	assign cy = WALL_W'(cell_y) << FRAC_W;

	always_comb begin
		if (hit_side == 1'b0) begin
			nx = dir_x_positive ? cx : cx + WALL_W'(ONE_Q16);
			ny = cy + WALL_W'(wall_fraction);
		end else begin
			nx = cx + WALL_W'(wall_fraction);
			ny = dir_y_positive ? cy : cy + WALL_W'(ONE_Q16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wfx_q   <= '0;
			wfy_q   <= '0;
			cwd_q   <= ONE_Q16;
			bound_q <= '0;
		end else if (accept && cmd == CMD_SETUP) begin
			wfx_q   <= nx;
			wfy_q   <= ny;
			cwd_q   <= wall_distance;
			bound_q <= boundary_row;
		end
	end

	assign twice = DIST_W'(row) << 1;
	assign hgt   = DIST_W'(SCREEN_HEIGHT);
	assign span  = (twice >= hgt) ? twice - hgt : hgt - twice;

	assign enq = accept && cmd == CMD_ROW;

	always_comb begin
		enq_entry.row  = row;
		enq_entry.span = span;
		// horizon row or zero wall distance: full weight on the wall point
		enq_entry.one  = (span == '0) || (cwd_q == '0);
		enq_entry.ceil = row < bound_q;
		enq_entry.wfx  = wfx_q;
		enq_entry.wfy  = wfy_q;
		enq_entry.cwd  = cwd_q;
	end

endmodule

FILE: rtl/rfc_queue.sv
// Short queue of row requests between front and back end.
`timescale 1ns / 1ps
module rfc_queue import rfc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   enq,
	input  entry_t enq_entry,
	output logic   full,
	input  logic   deq,
	output logic   q_empty,
	output entry_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]    cnt_q;

	assign full    = cnt_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign q_empty = cnt_q == '0;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= enq_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/rfc_back.sv
// Back end: row distance and weight dividers, blend and texel scaling.
`timescale 1ns / 1ps
module rfc_back import rfc_pkg::*; #(
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int TEX_SIZE      = TEX_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  entry_t           head,
	output logic             deq,
	input  logic [POS_W-1:0] player_x,
	input  logic [POS_W-1:0] player_y,
	input  logic             pop,
	output logic             empty,
	output logic [ROW_W-1:0] out_row,
	output logic [TEX_W-1:0] texel_u,
	output logic [TEX_W-1:0] texel_v,
	output logic             is_ceiling
);

	localparam int NUM_W = $clog2(SCREEN_HEIGHT + 1) + FRAC_W;
	localparam logic [NUM_W-1:0] NUM = NUM_W'(SCREEN_HEIGHT) << FRAC_W;

	logic en;

	// stage group 1: row distance divider, one quotient bit a stage
	logic              d1_v_s1 [NUM_W];
	logic [DIST_W-1:0] d1_r_s1 [NUM_W];
	logic [NUM_W-1:0]  d1_q_s1 [NUM_W];
	entry_t            d1_e_s1 [NUM_W];

	// stage 2: clamp test against the wall distance
	logic              cm_v_s2, cm_sat_s2;
	logic [POS_W-1:0]  cm_r_s2;
	entry_t            cm_e_s2;

	// stage group 3: weight divider
	logic              d2_v_s3   [FRAC_W];
	logic              d2_sat_s3 [FRAC_W];
	logic [POS_W-1:0]  d2_r_s3   [FRAC_W];
	logic [FRAC_W-1:0] d2_q_s3   [FRAC_W];
	entry_t            d2_e_s3   [FRAC_W];

	logic              ml_v_s4, ml_ceil_s4;
	logic [ROW_W-1:0]  ml_row_s4;
	logic [31:0]       ml_ax_s4, ml_bx_s4, ml_ay_s4, ml_by_s4;

	logic              ad_v_s5, ad_ceil_s5;
	logic [ROW_W-1:0]  ad_row_s5;
	logic [FRAC_W-1:0] ad_fx_s5, ad_fy_s5;

	logic              o_v_s6;

	assign en    = !o_v_s6 || pop;
	assign deq   = en && !q_empty;
	assign empty = !o_v_s6;

	for (genvar k = 0; k < NUM_W; k++) begin : g_div1
		logic              in_v, ge;
		logic [DIST_W-1:0] in_r;
		logic [NUM_W-1:0]  in_q;
		entry_t            in_e;
		logic [DIST_W:0]   t;

		if (k == 0) begin : g_first
			assign in_v = !q_empty;
			assign in_r = '0;
			assign in_q = '0;
			assign in_e = head;
		end else begin : g_next
			assign in_v = d1_v_s1[k-1];
			assign in_r = d1_r_s1[k-1];
			assign in_q = d1_q_s1[k-1];
			assign in_e = d1_e_s1[k-1];
		end

		assign t  = {in_r, NUM[NUM_W-1-k]};
		assign ge = t >= {1'b0, in_e.span};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_v_s1[k] <= 1'b0;
			end else if (en) begin
				d1_v_s1[k] <= in_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d1_r_s1[k] <= ge ? DIST_W'(t - {1'b0, in_e.span}) : DIST_W'(t);
				d1_q_s1[k] <= {in_q[NUM_W-2:0], ge};
				d1_e_s1[k] <= in_e;
			end
		end
	end

	logic [NUM_W-1:0] rdist;
	assign rdist = d1_q_s1[NUM_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm_v_s2 <= 1'b0;
		end else if (en) begin
			cm_v_s2 <= d1_v_s1[NUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// weight of one or more: clamp, skip the fraction
			cm_sat_s2 <= d1_e_s1[NUM_W-1].one ||
				(32'(rdist) >= 32'(d1_e_s1[NUM_W-1].cwd));
			cm_r_s2   <= POS_W'(rdist);
			cm_e_s2   <= d1_e_s1[NUM_W-1];
		end
	end

	for (genvar k = 0; k < FRAC_W; k++) begin : g_div2
		logic              in_v, in_sat, ge;
		logic [POS_W-1:0]  in_r;
		logic [FRAC_W-1:0] in_q;
		entry_t            in_e;
		logic [POS_W:0]    t;

		if (k == 0) begin : g_first
			assign in_v   = cm_v_s2;
			assign in_sat = cm_sat_s2;
			assign in_r   = cm_r_s2;
			assign in_q   = '0;
			assign in_e   = cm_e_s2;
		end else begin : g_next
			assign in_v   = d2_v_s3[k-1];
			assign in_sat = d2_sat_s3[k-1];
			assign in_r   = d2_r_s3[k-1];
			assign in_q   = d2_q_s3[k-1];
			assign in_e   = d2_e_s3[k-1];
		end

		assign t  = {in_r, 1'b0};
		assign ge = t >= {1'b0, in_e.cwd};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_v_s3[k] <= 1'b0;
			end else if (en) begin
				d2_v_s3[k] <= in_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d2_sat_s3[k] <= in_sat;
				d2_r_s3[k]   <= ge ? POS_W'(t - {1'b0, in_e.cwd}) : POS_W'(t);
				d2_q_s3[k]   <= {in_q[FRAC_W-2:0], ge};
				d2_e_s3[k]   <= in_e;
			end
		end
	end

	logic [FRAC_W:0] w, wc;
	entry_t          le;

	assign le = d2_e_s3[FRAC_W-1];
	assign w  = d2_sat_s3[FRAC_W-1] ? (FRAC_W+1)'(ONE_Q16) : {1'b0, d2_q_s3[FRAC_W-1]};
	assign wc = (FRAC_W+1)'(ONE_Q16) - w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ml_v_s4 <= 1'b0;
			ad_v_s5 <= 1'b0;
			o_v_s6  <= 1'b0;
		end else if (en) begin
			ml_v_s4 <= d2_v_s3[FRAC_W-1];
			ad_v_s5 <= ml_v_s4;
			o_v_s6  <= ad_v_s5;
		end
	end

	logic [31:0] sx, sy, tu, tv;

	assign sx = ml_ax_s4 + ml_bx_s4;
	assign sy = ml_ay_s4 + ml_by_s4;
	assign tu = 32'(ad_fx_s5) * 32'(TEX_SIZE);
	assign tv = 32'(ad_fy_s5) * 32'(TEX_SIZE);

	always_ff @(posedge clk) begin
		if (en) begin
			// only the low 32 bits feed the fraction of the blended point
			ml_ax_s4   <= 32'(32'(w) * 32'(le.wfx));
			ml_bx_s4   <= 32'(32'(wc) * 32'(player_x));
			ml_ay_s4   <= 32'(32'(w) * 32'(le.wfy));
			ml_by_s4   <= 32'(32'(wc) * 32'(player_y));
			ml_row_s4  <= le.row;
			ml_ceil_s4 <= le.ceil;

			ad_fx_s5   <= sx[31:FRAC_W];
			ad_fy_s5   <= sy[31:FRAC_W];
			ad_row_s5  <= ml_row_s4;
			ad_ceil_s5 <= ml_ceil_s4;

			texel_u    <= tu[FRAC_W+TEX_W-1:FRAC_W];
			texel_v    <= tv[FRAC_W+TEX_W-1:FRAC_W];
			out_row    <= ad_row_s5;
			is_ceiling <= ad_ceil_s5;
		end
	end

endmodule
